// ===== rtl/nine_bit_word_link_codec_unit_defines.svh =====
// assertion macros for the nine-bit word link codec checker
// used by nbwlc_checker.sv; expects signals named clock and reset in scope
`ifndef NINE_BIT_WORD_LINK_CODEC_UNIT_DEFINES_SVH
`define NINE_BIT_WORD_LINK_CODEC_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define NBWLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked on every clock edge, reset included
`define NBWLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/nbwlc_pkg.sv =====
// shared types and constants of the nine-bit word link codec
// no dependencies; used by the front, queue, back and top level
`default_nettype none

package nbwlc_pkg;

   // default sizes handed down from the top level
   localparam int RING_DEPTH_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // link byte tags
   localparam logic [7:0] TX_HI_TAG   = 8'h80;
   localparam logic [7:0] TX_LO_TAG   = 8'hA0;
   localparam logic [7:0] TX_READ_REQ = 8'hB0;

   // frame header limits
   localparam logic [2:0] FRAME_COUNT_MAX = 3'd5;
   localparam logic [2:0] FRAME_POS_START = 3'd4;

   // echo discard counter saturation
   localparam logic [7:0] ECHO_MAX = 8'hFF;

   // input item modes
   typedef enum logic [1:0] {
      MODE_SEND,
      MODE_RX_BYTE,
      MODE_TAKE,
      MODE_UNUSED
   } mode_type;

   // commands passed from front to back
   typedef enum logic [1:0] {
      CMD_SEND,
      CMD_STORE,
      CMD_FRAME_ERR,
      CMD_TAKE
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [8:0] word;
   } cmd_entry_type;

   // one result item
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [8:0] word_out;
      logic       word_valid;
      logic       word_dropped;
      logic       ring_overflow;
      logic       frame_error;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/nbwlc_if.sv =====
// valid/ready channel interfaces for request and response items
// no dependencies
`default_nettype none

interface nbwlc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [8:0] word_in;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output word_in, output rx_byte, input ready);
   modport sink   (input valid, input mode, input word_in, input rx_byte, output ready);
endinterface

interface nbwlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_valid;
   logic [8:0] word_out;
   logic       word_valid;
   logic       word_dropped;
   logic       ring_overflow;
   logic       frame_error;
   logic       last;

   modport source (output valid, output tx_byte, output tx_valid, output word_out,
                   output word_valid, output word_dropped, output ring_overflow,
                   output frame_error, output last, input ready);
   modport sink   (input valid, input tx_byte, input tx_valid, input word_out,
                   input word_valid, input word_dropped, input ring_overflow,
                   input frame_error, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/nine_bit_word_link_codec_unit.sv =====
// channel  direction  handshake     payload
// req_chan in         valid/ready   mode, word_in, rx_byte
// rsp_chan out        valid/ready   tx_byte, tx_valid, word_out, word_valid,
//                                   word_dropped, ring_overflow, frame_error, last
//
// one item accepted per cycle while the command queue has room; a send item
// gives two results, all others at most one, so the result port sets the pace
// an accepted item passes the queue, then the execute and output registers
// reset is synchronous; the word ring needs no clearing
// the command queue holds QUEUE_DEPTH items so either side may stall alone
//
// top level of the nine-bit word link codec
// depends on nbwlc_pkg, nbwlc_if, nbwlc_front, nbwlc_queue, nbwlc_back
`default_nettype none

module nine_bit_word_link_codec_unit #(
   parameter int RING_DEPTH  = nbwlc_pkg::RING_DEPTH_DEF,
   parameter int QUEUE_DEPTH = nbwlc_pkg::QUEUE_DEPTH_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   nbwlc_req_if.sink   req_chan,
   nbwlc_rsp_if.source rsp_chan
);
   import nbwlc_pkg::*;

   logic          push_valid, push_ready;
   cmd_entry_type push_entry;
   logic          pop_valid, pop_ready;
   cmd_entry_type pop_entry;

   // item intake and frame parsing
   nbwlc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // decoupling queue
   nbwlc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // ring and result generation
   nbwlc_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/nbwlc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module nbwlc_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/nbwlc_front.sv =====
// front end: accepts request items, parses reply frames, issues commands
// depends on nbwlc_pkg and nbwlc_req_if
`default_nettype none

module nbwlc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   nbwlc_req_if.sink                req_chan,
   output logic                     push_valid,
   output nbwlc_pkg::cmd_entry_type push_entry,
   input  wire logic                push_ready
);
   import nbwlc_pkg::*;

   logic [2:0] remaining_ff, remaining_in;
   logic [4:0] high_ff, high_in;
   logic [2:0] pos_ff, pos_in;
   logic       accept;
   logic       has_cmd;
   logic [7:0] high_shifted;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign high_shifted   = {3'b000, high_ff} >> pos_ff;

   // classify the item and advance the frame parser
   always_comb begin
      has_cmd         = 1'b0;
      push_entry.cmd  = CMD_TAKE;
      push_entry.word = req_chan.word_in;
      remaining_in    = remaining_ff;
      high_in         = high_ff;
      pos_in          = pos_ff;
      unique case (mode_type'(req_chan.mode))
         MODE_SEND: begin
            has_cmd        = 1'b1;
            push_entry.cmd = CMD_SEND;
         end
         MODE_RX_BYTE: begin
            if (remaining_ff == 3'd0) begin
               // header byte
               if (req_chan.rx_byte[2:0] > FRAME_COUNT_MAX) begin
                  has_cmd        = 1'b1;
                  push_entry.cmd = CMD_FRAME_ERR;
               end else begin
                  high_in      = req_chan.rx_byte[7:3];
                  remaining_in = req_chan.rx_byte[2:0];
                  pos_in       = FRAME_POS_START;
               end
            end else begin
               // data byte, ninth bit from the header
               has_cmd         = 1'b1;
               push_entry.cmd  = CMD_STORE;
               push_entry.word = {high_shifted[0], req_chan.rx_byte};
               remaining_in    = remaining_ff - 3'd1;
               pos_in          = pos_ff - 3'd1;
            end
         end
         MODE_TAKE: begin
            has_cmd        = 1'b1;
            push_entry.cmd = CMD_TAKE;
         end
         MODE_UNUSED: begin
            has_cmd = 1'b0;
         end
         default: begin
            has_cmd = 1'b0;
         end
      endcase
   end

   assign push_valid = accept && has_cmd;

   // frame parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 3'd0;
         high_ff      <= 5'd0;
         pos_ff       <= FRAME_POS_START;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         high_ff      <= high_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nbwlc_queue.sv =====
// short command queue between front and back
// depends on nbwlc_pkg
`default_nettype none

module nbwlc_queue #(
   parameter int DEPTH = nbwlc_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  nbwlc_pkg::cmd_entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output nbwlc_pkg::cmd_entry_type pop_entry,
   input  wire logic                pop_ready
);
   import nbwlc_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign push_ready = count_ff < CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nbwlc_back.sv =====
// back end: executes commands on the receive ring, builds result items
// depends on nbwlc_pkg, nbwlc_rsp_if and nbwlc_ram
`default_nettype none

module nbwlc_back #(
   parameter int RING_DEPTH = nbwlc_pkg::RING_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  nbwlc_pkg::cmd_entry_type pop_entry,
   output logic                     pop_ready,
   nbwlc_rsp_if.source              rsp_chan
);
   import nbwlc_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    echo_ff, echo_in;
   logic          phase_ff, phase_in;

   logic          p1_valid_ff;
   result_type    p1_ff;
   logic          p1_need_word_ff;
   logic          out_valid_ff;
   result_type    out_ff;
   result_type    out_in;

   result_type    res;
   logic          has_res;
   logic          need_word;
   logic          out_free, p1_free, fire;
   logic          ram_wr, ram_rd;
   logic [8:0]    ram_rdata;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign p1_free  = !p1_valid_ff || out_free;
   assign fire     = pop_valid && p1_free;

   // command execution
   always_comb begin
      res       = '0;
      has_res   = 1'b0;
      need_word = 1'b0;
      pop_ready = 1'b0;
      ram_wr    = 1'b0;
      ram_rd    = 1'b0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      echo_in   = echo_ff;
      phase_in  = phase_ff;
      if (fire) begin
         unique case (pop_entry.cmd)
            CMD_SEND: begin
               has_res      = 1'b1;
               res.tx_valid = 1'b1;
               if (!phase_ff) begin
                  // upper five bits first, command stays queued
                  res.tx_byte = TX_HI_TAG | {3'b000, pop_entry.word[8:4]};
                  phase_in    = 1'b1;
               end else begin
                  res.tx_byte = TX_LO_TAG | {4'b0000, pop_entry.word[3:0]};
                  res.last    = 1'b1;
                  phase_in    = 1'b0;
                  pop_ready   = 1'b1;
                  if (echo_ff != ECHO_MAX) begin
                     echo_in = echo_ff + 8'd1;
                  end
               end
            end
            CMD_STORE: begin
               pop_ready = 1'b1;
               if (fill_ff >= FW'(RING_DEPTH)) begin
                  has_res           = 1'b1;
                  res.ring_overflow = 1'b1;
                  res.last          = 1'b1;
               end else begin
                  ram_wr  = 1'b1;
                  tail_in = (tail_ff == AW'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            CMD_FRAME_ERR: begin
               pop_ready       = 1'b1;
               has_res         = 1'b1;
               res.frame_error = 1'b1;
               res.last        = 1'b1;
            end
            CMD_TAKE: begin
               pop_ready = 1'b1;
               has_res   = 1'b1;
               res.last  = 1'b1;
               if (fill_ff == '0) begin
                  res.tx_byte  = TX_READ_REQ;
                  res.tx_valid = 1'b1;
               end else begin
                  // head word arrives from the ram in the next cycle
                  ram_rd    = 1'b1;
                  need_word = 1'b1;
                  head_in   = (head_ff == AW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  fill_in   = fill_ff - 1'b1;
                  if (echo_ff != 8'd0) begin
                     echo_in          = echo_ff - 8'd1;
                     res.word_dropped = 1'b1;
                  end else begin
                     res.word_valid = 1'b1;
                  end
               end
            end
            default: begin
               pop_ready = 1'b0;
            end
         endcase
      end
   end

   // merge ram data into the outgoing item
   always_comb begin
      out_in          = p1_ff;
      out_in.word_out = p1_need_word_ff ? ram_rdata : 9'd0;
   end

   // ring control and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         echo_ff      <= 8'd0;
         phase_ff     <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         echo_ff  <= echo_in;
         phase_ff <= phase_in;
         if (p1_free) begin
            p1_valid_ff <= fire && has_res;
         end
         if (out_free) begin
            out_valid_ff <= p1_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (p1_free) begin
         p1_ff           <= res;
         p1_need_word_ff <= need_word;
      end
      if (out_free && p1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   // receive ring storage
   nbwlc_ram #(
      .WIDTH (9),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (tail_ff),
      .wr_data (pop_entry.word),
      .rd_en   (ram_rd),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.tx_byte       = out_ff.tx_byte;
   assign rsp_chan.tx_valid      = out_ff.tx_valid;
   assign rsp_chan.word_out      = out_ff.word_out;
   assign rsp_chan.word_valid    = out_ff.word_valid;
   assign rsp_chan.word_dropped  = out_ff.word_dropped;
   assign rsp_chan.ring_overflow = out_ff.ring_overflow;
   assign rsp_chan.frame_error   = out_ff.frame_error;
   assign rsp_chan.last          = out_ff.last;

endmodule

`default_nettype wire

// ===== rtl/nbwlc_checker.sv =====
// port-level checks on the result channel of the codec, bound to the top level
// depends on nine_bit_word_link_codec_unit_defines.svh
`default_nettype none

`include "nine_bit_word_link_codec_unit_defines.svh"

module nbwlc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] tx_byte,
   input wire logic       tx_valid,
   input wire logic [8:0] word_out,
   input wire logic       word_valid,
   input wire logic       word_dropped,
   input wire logic       ring_overflow,
   input wire logic       frame_error,
   input wire logic       last
);

   // no result right after reset
   `NBWLC_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_valid, "result valid after reset")

   // a stalled result stays offered
   `NBWLC_ASSERT(a_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "result withdrawn")

   // each result carries exactly one kind of event
   `NBWLC_ASSERT(a_one_kind, rsp_valid |-> $onehot({tx_valid, word_valid, word_dropped, ring_overflow, frame_error}), "result kind not unique")

   // only the upper send byte is a non-last result
   `NBWLC_ASSERT(a_non_last_send, rsp_valid && !last |-> tx_valid && tx_byte[7:5] == 3'b100, "bad non-last result")

   // word field is clear unless a word was taken
   `NBWLC_ASSERT(a_word_clear, rsp_valid && !word_valid && !word_dropped |-> word_out == 9'd0, "stray word data")

endmodule

bind nine_bit_word_link_codec_unit nbwlc_checker u_nbwlc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .tx_byte       (rsp_chan.tx_byte),
   .tx_valid      (rsp_chan.tx_valid),
   .word_out      (rsp_chan.word_out),
   .word_valid    (rsp_chan.word_valid),
   .word_dropped  (rsp_chan.word_dropped),
   .ring_overflow (rsp_chan.ring_overflow),
   .frame_error   (rsp_chan.frame_error),
   .last          (rsp_chan.last)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the nine-bit word link codec unit
// needs nbwlc_pkg, nbwlc_if and the codec rtl; runs directed then random items

module testbench;
   import nbwlc_pkg::*;

   localparam int STALL_MAX   = 11;
   localparam int SETTLE_WAIT = 20;
   localparam int HANG_LIMIT  = 2000;
   localparam int ITEM_TOTAL  = 1900;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      mode_type   mode;
      logic [8:0] word;
      logic [7:0] rx;
      bit         drain;
   } link_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nbwlc_req_if req_bus ();
   nbwlc_rsp_if rsp_bus ();

   nine_bit_word_link_codec_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // items waiting to be sent and results still owed by the codec
   link_item_type pending_items[$];
   result_type    expected_results[$];
   logic          link_idle = 1'b1;
   int            mismatch_count = 0;
   int            gen_remaining = 0;
   bit            drain_next = 1'b0;

   // shadow of the codec state
   logic [8:0] shadow_ring [RING_DEPTH_DEF];
   int         shadow_head, shadow_tail, shadow_fill;
   logic [7:0] shadow_echo;
   logic [4:0] shadow_high;
   logic [2:0] shadow_left, shadow_pos;

   // clock
   always #5 clock = ~clock;

   // per-item wait, with calm stretches where nothing idles
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      return calm ? 0 : $urandom_range(0, STALL_MAX);
   endfunction

   // stimulus building; tracks frame sync so frames stay well formed
   task automatic queue_item(input mode_type m, input logic [8:0] w, input logic [7:0] b);
      link_item_type it;
      it.mode  = m;
      it.word  = w;
      it.rx    = b;
      it.drain = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
      if (m == MODE_RX_BYTE) begin
         if (gen_remaining != 0) begin
            gen_remaining--;
         end else if (b[2:0] <= FRAME_COUNT_MAX) begin
            gen_remaining = b[2:0];
         end
      end
   endtask

   task automatic queue_rx(input logic [7:0] b);
      queue_item(MODE_RX_BYTE, 9'($urandom_range(0, 511)), b);
   endtask

   task automatic queue_send(input logic [8:0] w);
      queue_item(MODE_SEND, w, 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_take();
      queue_item(MODE_TAKE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_frame(input int count);
      while (gen_remaining != 0) queue_rx(8'($urandom_range(0, 255)));
      queue_rx({5'($urandom_range(0, 31)), 3'(count)});
      repeat (count) queue_rx(8'($urandom_range(0, 255)));
   endtask

   // expected results of one accepted item
   task automatic predict_results(input mode_type m, input logic [8:0] w, input logic [7:0] b);
      result_type r;
      r = '0;
      case (m)
         MODE_SEND: begin
            r.tx_byte  = TX_HI_TAG | {3'b000, w[8:4]};
            r.tx_valid = 1'b1;
            expected_results.push_back(r);
            r.tx_byte  = TX_LO_TAG | {4'b0000, w[3:0]};
            r.last     = 1'b1;
            expected_results.push_back(r);
            if (shadow_echo != ECHO_MAX) shadow_echo++;
         end
         MODE_RX_BYTE: begin
            if (shadow_left == 3'd0) begin
               // header: bad counts are dropped, next byte is a header again
               if (b[2:0] > FRAME_COUNT_MAX) begin
                  r.frame_error = 1'b1;
                  r.last        = 1'b1;
                  expected_results.push_back(r);
               end else begin
                  shadow_high = b[7:3];
                  shadow_left = b[2:0];
                  shadow_pos  = FRAME_POS_START;
               end
            end else begin
               // data byte picks up its ninth bit from the header
               if (shadow_fill >= RING_DEPTH_DEF) begin
                  r.ring_overflow = 1'b1;
                  r.last          = 1'b1;
                  expected_results.push_back(r);
               end else begin
                  shadow_ring[shadow_tail] = {shadow_high[shadow_pos], b};
                  shadow_tail = (shadow_tail + 1) % RING_DEPTH_DEF;
                  shadow_fill++;
               end
               shadow_left--;
               shadow_pos--;
            end
         end
         MODE_TAKE: begin
            r.last = 1'b1;
            if (shadow_fill == 0) begin
               r.tx_byte  = TX_READ_REQ;
               r.tx_valid = 1'b1;
            end else begin
               r.word_out  = shadow_ring[shadow_head];
               shadow_head = (shadow_head + 1) % RING_DEPTH_DEF;
               shadow_fill--;
               if (shadow_echo != 8'd0) begin
                  shadow_echo--;
                  r.word_dropped = 1'b1;
               end else begin
                  r.word_valid = 1'b1;
               end
            end
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic note_failure(input string msg);
      if (mismatch_count < REPORT_MAX) $display("%s", msg);
      mismatch_count++;
   endtask

   function automatic string show_result(input result_type r);
      return $sformatf("tx=%h/%b word=%h valid=%b drop=%b ovf=%b ferr=%b last=%b",
                       r.tx_byte, r.tx_valid, r.word_out, r.word_valid, r.word_dropped,
                       r.ring_overflow, r.frame_error, r.last);
   endfunction

   // driver: presents pending items with random gaps
   int            send_gap = 0;
   bit            send_calm = 1'b0;
   link_item_type next_item;

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_UNUSED;
      req_bus.word_in = '0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      (!pending_items[0].drain || (!req_bus.valid && link_idle))) begin
            next_item = pending_items.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.mode    <= next_item.mode;
            req_bus.word_in <= next_item.word;
            req_bus.rx_byte <= next_item.rx;
            send_gap = draw_gap(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted items, checks accepted results, stalls ready
   int         recv_stall = 0;
   bit         recv_calm = 1'b0;
   result_type seen, want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall = 0;
         shadow_head = 0;
         shadow_tail = 0;
         shadow_fill = 0;
         shadow_echo = '0;
         shadow_high = '0;
         shadow_left = '0;
         shadow_pos  = FRAME_POS_START;
         link_idle  <= 1'b1;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_results(mode_type'(req_bus.mode), req_bus.word_in, req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.tx_byte       = rsp_bus.tx_byte;
            seen.tx_valid      = rsp_bus.tx_valid;
            seen.word_out      = rsp_bus.word_out;
            seen.word_valid    = rsp_bus.word_valid;
            seen.word_dropped  = rsp_bus.word_dropped;
            seen.ring_overflow = rsp_bus.ring_overflow;
            seen.frame_error   = rsp_bus.frame_error;
            seen.last          = rsp_bus.last;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result: %s", show_result(seen)));
            end else begin
               want = expected_results.pop_front();
               if (seen !== want)
                  note_failure($sformatf("result mismatch: expected %s, got %s",
                                         show_result(want), show_result(seen)));
            end
            recv_stall = draw_gap(recv_calm);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         link_idle <= (expected_results.size() == 0);
      end
   end

   // watchdog on cycles with no item moving on either side
   int hang_count = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // stimulus and end of run
   initial begin
      // directed: read request on empty ring, word extremes, frames, errors
      queue_take();
      queue_send(9'h000);
      queue_send(9'h1FF);
      queue_rx(8'hFD);
      queue_rx(8'h00);
      queue_rx(8'hFF);
      queue_rx(8'h55);
      queue_rx(8'hAA);
      queue_rx(8'h01);
      queue_rx(8'h06);
      queue_rx(8'hFF);
      queue_rx(8'h00);
      queue_rx(8'h02);
      queue_rx(8'h00);
      queue_rx(8'hFF);
      // two echoes dropped, then words delivered until the ring is empty
      repeat (7) queue_take();
      queue_item(MODE_UNUSED, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
      queue_take();

      // echo counter saturation, then drain it with full frames
      drain_next = 1'b1;
      repeat (260) queue_send(9'($urandom_range(0, 511)));
      repeat (54) begin
         queue_frame(5);
         repeat (5) queue_take();
      end

      // random mix of frames, takes, sends and noise
      drain_next = 1'b1;
      while (pending_items.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
         case ($urandom_range(0, 15))
            0, 1, 2, 3:    queue_frame($urandom_range(0, 5));
            4, 5, 6, 7, 8: repeat ($urandom_range(1, 10)) queue_take();
            9, 10:         repeat ($urandom_range(1, 2)) queue_send(9'($urandom_range(0, 511)));
            11:            repeat (4) queue_frame(5);
            12:            queue_rx(8'($urandom_range(0, 255)));
            13: begin
               // bad header count, or a byte that lands inside a frame
               queue_rx({5'($urandom_range(0, 31)), 3'($urandom_range(6, 7))});
            end
            14:            queue_item(MODE_UNUSED, 9'($urandom_range(0, 511)),
                                      8'($urandom_range(0, 255)));
            default: begin
               // broken frame: header and fewer bytes than it announces
               while (gen_remaining != 0) queue_rx(8'($urandom_range(0, 255)));
               queue_rx({5'($urandom_range(0, 31)), 3'($urandom_range(2, 5))});
               queue_rx(8'($urandom_range(0, 255)));
            end
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_bus.valid || !link_idle) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
